// File: design/cubic_spline_evaluator_macros.svh
// Assertion macros shared by the spline evaluator modules
`ifndef CUBIC_SPLINE_EVALUATOR_MACROS_SVH
`define CUBIC_SPLINE_EVALUATOR_MACROS_SVH

// Implication checked on every clock edge outside reset
`define CSE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the next cycle
`define CSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/cse_pkg.sv
// Package: types and constants of the cubic spline evaluator
`timescale 1ns / 1ps
`default_nettype none
package cse_pkg;

  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    FUNC_VALUE = 2'd0,
    FUNC_DERIV = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WAIT,
    ST_WALK,
    ST_COEF,
    ST_HORNER,
    ST_DIV,
    ST_EXTRA,
    ST_DONE
  } state_e;

  localparam logic [0:0] REG_KNOT_COUNT = 1'b0;

  // Shared multiply-accumulate control
  typedef struct packed {
    logic start;
    logic busy;
  } mac_ctl_t;

endpackage
`default_nettype wire

// File: design/cse_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read
`timescale 1ns / 1ps
`default_nettype none
module cse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: design/cse_div.sv
// Restoring divider: signed quotient, truncated toward zero, one bit a cycle
`timescale 1ns / 1ps
`default_nettype none
`include "cubic_spline_evaluator_macros.svh"
module cse_div #(
  parameter int unsigned NumW = 50,
  parameter int unsigned DenW = 33
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic signed [NumW-1:0] num_i,
  input  wire logic signed [DenW-1:0] den_i,
  output logic                        done_o,
  output logic signed [NumW:0]        quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DenW:0]   trial;

  // One quotient bit per cycle on magnitudes
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = '0;
    if (start_i) begin
      quo_d  = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
      den_d  = den_i[DenW-1] ? DenW'(-den_i) : DenW'(den_i);
      neg_d  = num_i[NumW-1] ^ den_i[DenW-1];
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[DenW-1:0], quo_q[NumW-1]} - {1'b0, den_q};
      if (!trial[DenW]) begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DenW-1:0], quo_q[NumW-1]};
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  logic busy_dly_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_dly_q <= 1'b0;
    else         busy_dly_q <= busy_q;
  end
  assign done_o = busy_dly_q && !busy_q;
  assign quot_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

  `CSE_ASSERT_NEXT(a_div_start_busy, clk_i, rst_ni, start_i, busy_q, "divider did not start")
  `CSE_ASSERT_IMP(a_div_cnt_range, clk_i, rst_ni, busy_q,
    (cnt_q != '0) && (cnt_q <= CntW'(NumW)), "divider count out of range")
  `CSE_ASSERT_NEXT(a_div_done_once, clk_i, rst_ni, done_o, !done_o, "divider done twice")
endmodule
`default_nettype wire

// File: design/cubic_spline_evaluator.sv
// Cubic spline evaluator: walk sequencer, shared multiply-add unit, serial divider
// Sequence: knot walk, then coefficient fetch, then a multiply and an add per Horner term
//   (three terms for a value, two for a derivative). Extrapolation divides for the end
//   slope instead, then multiplies and adds for a value; zero spacing skips the division.
// Requests: one at a time; a write is done when accepted; the next request is taken only
//   after the result has left the output. The knot walk and the divider set the rate.
// Reset: asynchronous active low; knot_count to 2, last interval to 0; tables undefined.
`timescale 1ns / 1ps
`default_nettype none
`include "cubic_spline_evaluator_macros.svh"
module cubic_spline_evaluator #(
  parameter int unsigned MAX_KNOTS = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [1:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: point[31:0], entry_index[37:32], knot_value[69:38], coef_const[101:70],
  //   coef_lin[133:102], coef_quad[165:134], coef_cub[197:166], zero pad to 200
  input  wire logic [199:0] s_axis_tdata,
  // tuser: func[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: result_value[31:0], interval_used[37:32], extrapolated[38], saturated[39]
  output logic [39:0]       m_axis_tdata
);
  localparam int unsigned AW   = $clog2(MAX_KNOTS);
  localparam int unsigned CntW = $clog2(MAX_KNOTS + 1);
  localparam int unsigned W    = cse_pkg::DataW;
  localparam logic signed [W:0] SMAX = (W+1)'(33'sh0_7FFF_FFFF);
  localparam logic signed [W:0] SMIN = -(W+1)'(33'sh0_8000_0000);

  // Configuration register
  logic [6:0] kcount_q;
  assign pready = 1'b1;
  assign prdata = {25'd0, kcount_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) kcount_q <= 7'd2;
    else if (psel && penable && pwrite && paddr[1:0] == {cse_pkg::REG_KNOT_COUNT, 1'b0})
      kcount_q <= pwdata[6:0];
  end

  // Input fields
  cse_pkg::func_e in_func;
  logic [5:0] in_idx;
  assign in_func = cse_pkg::func_e'(s_axis_tuser);
  assign in_idx  = s_axis_tdata[37:32];

  cse_pkg::state_e st_q, st_d;
  logic acc;
  assign s_axis_tready = (st_q == cse_pkg::ST_IDLE) && !m_axis_tvalid;
  assign acc = s_axis_tvalid && s_axis_tready;

  // Tables: knot store has two ports via two copies
  logic ram_we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [W-1:0] knot_a, knot_b, c0_r, c1_r, c2_r, c3_r, c0_b;
  assign ram_we = acc && in_func == cse_pkg::FUNC_WRITE && (32'(in_idx) < MAX_KNOTS);
  assign waddr  = AW'(in_idx);

  cse_ram #(.Width(W), .Depth(MAX_KNOTS)) u_knot_a (.clk_i, .we_i(ram_we), .waddr_i(waddr),
    .wdata_i(s_axis_tdata[69:38]), .raddr_i(raddr_a), .rdata_o(knot_a));
  cse_ram #(.Width(W), .Depth(MAX_KNOTS)) u_knot_b (.clk_i, .we_i(ram_we), .waddr_i(waddr),
    .wdata_i(s_axis_tdata[69:38]), .raddr_i(raddr_b), .rdata_o(knot_b));
  cse_ram #(.Width(W), .Depth(MAX_KNOTS)) u_c0 (.clk_i, .we_i(ram_we), .waddr_i(waddr),
    .wdata_i(s_axis_tdata[101:70]), .raddr_i(raddr_a), .rdata_o(c0_r));
  cse_ram #(.Width(W), .Depth(MAX_KNOTS)) u_c0b (.clk_i, .we_i(ram_we), .waddr_i(waddr),
    .wdata_i(s_axis_tdata[101:70]), .raddr_i(raddr_b), .rdata_o(c0_b));
  cse_ram #(.Width(W), .Depth(MAX_KNOTS)) u_c1 (.clk_i, .we_i(ram_we), .waddr_i(waddr),
    .wdata_i(s_axis_tdata[133:102]), .raddr_i(raddr_a), .rdata_o(c1_r));
  cse_ram #(.Width(W), .Depth(MAX_KNOTS)) u_c2 (.clk_i, .we_i(ram_we), .waddr_i(waddr),
    .wdata_i(s_axis_tdata[165:134]), .raddr_i(raddr_a), .rdata_o(c2_r));
  cse_ram #(.Width(W), .Depth(MAX_KNOTS)) u_c3 (.clk_i, .we_i(ram_we), .waddr_i(waddr),
    .wdata_i(s_axis_tdata[197:166]), .raddr_i(raddr_a), .rdata_o(c3_r));

  // Working registers
  logic [AW-1:0] idx_q, idx_d, last_q, last_d, top_q, top_d;
  logic signed [W-1:0] pt_q, pt_d;
  logic deriv_q, deriv_d, dir_q, dir_d, extra_q, extra_d, flag_q, flag_d;
  logic signed [W-1:0] t_q, t_d;
  logic signed [W:0] r_q, r_d;
  logic [1:0] step_q, step_d;
  logic signed [W-1:0] cq_q, cq_d, cl_q, cl_d, cc_q, cc_d, y1_q, y1_d;
  logic signed [2*W:0] prod_q, prod_d;
  logic mul_ph_q, mul_ph_d;
  logic [CntW-1:0] cnt_use;
  logic res_v_d;
  logic [39:0] res_d;

  // Knot count clipped to 2..MAX_KNOTS
  always_comb begin
    if (kcount_q < 7'd2) cnt_use = CntW'(2);
    else if (32'(kcount_q) > MAX_KNOTS) cnt_use = CntW'(MAX_KNOTS);
    else cnt_use = CntW'(kcount_q);
  end

  assign raddr_a = idx_d;
  assign raddr_b = AW'(idx_d + 1'b1);

  // Divider for the end slope
  logic div_start, div_done;
  logic signed [W+FRAC_BITS+1:0] div_num;
  logic signed [W:0] div_den;
  logic signed [W+FRAC_BITS+2:0] div_q;
  cse_div #(.NumW(W + FRAC_BITS + 2), .DenW(W + 1)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_q));

  // Shared multiplier: running term times offset from the knot
  logic signed [2*W:0] mul_p;
  assign mul_p = (2*W+1)'(t_q) * (2*W+1)'(r_q);

  logic signed [W:0] x0s, x1s, pts, dy, dx;
  logic signed [2*W:0] fl;
  logic signed [2*W+1:0] wsum;
  logic signed [W-1:0] addend;

  // Saturate helper
  function automatic logic [W:0] sat(input logic signed [2*W+1:0] v);
    logic [W:0] o;
    if (v > 66'(SMAX)) o = {1'b1, SMAX[W-1:0]};
    else if (v < 66'(SMIN)) o = {1'b1, SMIN[W-1:0]};
    else o = {1'b0, v[W-1:0]};
    return o;
  endfunction

  logic [W:0] sres;

  // Sequencer next state and datapath
  always_comb begin
    st_d = st_q; idx_d = idx_q; last_d = last_q; top_d = top_q; pt_d = pt_q;
    deriv_d = deriv_q; dir_d = dir_q; extra_d = extra_q; flag_d = flag_q;
    t_d = t_q; r_d = r_q; step_d = step_q; cq_d = cq_q; cl_d = cl_q; cc_d = cc_q;
    y1_d = y1_q; prod_d = prod_q; mul_ph_d = mul_ph_q;
    res_v_d = 1'b0; res_d = m_axis_tdata; div_start = 1'b0;
    x0s = $signed({knot_a[W-1], knot_a});
    x1s = $signed({knot_b[W-1], knot_b});
    pts = $signed({pt_q[W-1], pt_q});
    dy = $signed({c0_b[W-1], c0_b}) - $signed({c0_r[W-1], c0_r});
    dx = x1s - x0s;
    div_num = $signed({{(FRAC_BITS+1){dy[W]}}, dy}) <<< FRAC_BITS;
    div_den = dx;
    fl = prod_q >>> FRAC_BITS; wsum = '0; addend = '0; sres = '0;
    case (st_q)
      cse_pkg::ST_IDLE: begin
        if (acc && (in_func == cse_pkg::FUNC_VALUE || in_func == cse_pkg::FUNC_DERIV)) begin
          pt_d = s_axis_tdata[31:0];
          deriv_d = (in_func == cse_pkg::FUNC_DERIV);
          top_d = AW'(cnt_use - 2'd2);
          idx_d = (last_q > AW'(cnt_use - 2'd2)) ? AW'(cnt_use - 2'd2) : last_q;
          extra_d = 1'b0; flag_d = 1'b0; dir_d = 1'b0;
          st_d = cse_pkg::ST_WAIT;
        end
      end
      cse_pkg::ST_WAIT: st_d = cse_pkg::ST_WALK;
      // Each knot step passes back through ST_WAIT for the table read; dir_q set once walking right
      cse_pkg::ST_WALK: begin
        if (!dir_q && pts < x0s && idx_q != '0) begin
          idx_d = idx_q - 1'b1; st_d = cse_pkg::ST_WAIT;
        end else if (!dir_q && pts < x0s) begin
          extra_d = 1'b1; st_d = cse_pkg::ST_COEF;
        end else if (pts > x1s && idx_q < top_q) begin
          dir_d = 1'b1; idx_d = idx_q + 1'b1; st_d = cse_pkg::ST_WAIT;
        end else begin
          extra_d = (pts > x1s); st_d = cse_pkg::ST_COEF;
        end
      end
      cse_pkg::ST_COEF: begin
        last_d = idx_q;
        r_d = pts - x0s;
        cq_d = c2_r; cl_d = c1_r; cc_d = c0_r;
        if (extra_q) begin
          y1_d = c0_r;
          if (dx == '0) begin
            flag_d = 1'b1;
            t_d = (dy > 0) ? SMAX[W-1:0] : ((dy < 0) ? SMIN[W-1:0] : '0);
            st_d = cse_pkg::ST_EXTRA; mul_ph_d = 1'b0;
          end else begin
            div_start = 1'b1; st_d = cse_pkg::ST_DIV;
          end
        end else begin
          step_d = 2'd0; mul_ph_d = 1'b0;
          if (deriv_q) begin
            sres = sat(66'($signed(c3_r)) * 66'sd3);
            t_d = sres[W-1:0]; flag_d = sres[W];
          end else t_d = c3_r;
          st_d = cse_pkg::ST_HORNER;
        end
      end
      cse_pkg::ST_DIV: begin
        if (div_done) begin
          sres = sat(66'(div_q));
          t_d = sres[W-1:0]; flag_d = flag_q | sres[W];
          st_d = cse_pkg::ST_EXTRA; mul_ph_d = 1'b0;
        end
      end
      // Derivative: the slope itself; value: slope times offset, then add end ordinate
      cse_pkg::ST_EXTRA: begin
        if (deriv_q) begin
          res_v_d = 1'b1; res_d = {flag_q, 1'b1, 6'(idx_q), t_q};
          st_d = cse_pkg::ST_DONE;
        end else if (!mul_ph_q) begin
          prod_d = mul_p; mul_ph_d = 1'b1;
        end else begin
          wsum = (2*W+2)'(y1_q) + (2*W+2)'(fl);
          sres = sat(wsum);
          res_v_d = 1'b1;
          res_d = {flag_q | sres[W], 1'b1, 6'(idx_q), sres[W-1:0]};
          st_d = cse_pkg::ST_DONE;
        end
      end
      // Shared multiply then add for each term
      cse_pkg::ST_HORNER: begin
        if (!mul_ph_q) begin
          prod_d = mul_p; mul_ph_d = 1'b1;
        end else begin
          mul_ph_d = 1'b0;
          case (step_q)
            2'd0: addend = cq_q;
            2'd1: addend = cl_q;
            default: addend = cc_q;
          endcase
          if (deriv_q && step_q == 2'd0)
            wsum = ((2*W+2)'(addend) <<< 1) + (2*W+2)'(fl);
          else
            wsum = (2*W+2)'(addend) + (2*W+2)'(fl);
          sres = sat(wsum);
          t_d = sres[W-1:0]; flag_d = flag_q | sres[W];
          step_d = step_q + 1'b1;
          if ((deriv_q && step_q == 2'd1) || step_q == 2'd2) begin
            res_v_d = 1'b1;
            res_d = {flag_q | sres[W], 1'b0, 6'(idx_q), sres[W-1:0]};
            st_d = cse_pkg::ST_DONE;
          end
        end
      end
      cse_pkg::ST_DONE: if (!m_axis_tvalid) st_d = cse_pkg::ST_IDLE;
      default: st_d = cse_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= cse_pkg::ST_IDLE; last_q <= '0; m_axis_tvalid <= 1'b0;
      idx_q <= '0; mul_ph_q <= 1'b0;
    end else begin
      st_q <= st_d; last_q <= last_d; idx_q <= idx_d; mul_ph_q <= mul_ph_d;
      if (res_v_d) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d; pt_q <= pt_d; deriv_q <= deriv_d; dir_q <= dir_d;
    extra_q <= extra_d; flag_q <= flag_d; t_q <= t_d; r_q <= r_d; step_q <= step_d;
    cq_q <= cq_d; cl_q <= cl_d; cc_q <= cc_d; y1_q <= y1_d;
    prod_q <= prod_d;
    if (res_v_d) m_axis_tdata <= res_d;
  end

  `CSE_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, s_axis_tready, st_q == cse_pkg::ST_IDLE,
    "ready outside idle")
  `CSE_ASSERT_IMP(a_idx_range, clk_i, rst_ni, st_q == cse_pkg::ST_WALK, idx_q <= top_q,
    "walk index beyond last interval")
  `CSE_ASSERT_NEXT(a_result_held, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
endmodule
`default_nettype wire

// File: test/tb.sv
// Testbench for the cubic spline evaluator: directed and random tests with a self-checking predictor
`timescale 1ns / 1ps
`default_nettype none
module tb;

  localparam int unsigned KnotsMax = 64;
  localparam int unsigned FracW    = 16;
  localparam int unsigned Settle   = 200;
  localparam longint      Limit    = 2_000_000;

  // result of one evaluation request
  typedef struct {
    logic [31:0] value;
    logic [5:0]  interval;
    logic        extra;
    logic        clipped;
  } spline_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [199:0] s_axis_tdata = '0;  // point, entry_index, knot, const, lin, quad, cub, pad
  logic [1:0]   s_axis_tuser = '0;  // func
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;       // value, interval, extrapolated, saturated

  cubic_spline_evaluator dut (.*);

  // predictor state
  logic signed [31:0] knot_tab[KnotsMax], const_tab[KnotsMax];
  logic signed [31:0] lin_tab[KnotsMax], quad_tab[KnotsMax], cub_tab[KnotsMax];
  int          last_iv = 0;
  logic [6:0]  knot_cfg = 7'd2;
  bit          clip_seen;
  spline_res_t pending[$];

  int     errors = 0;
  longint cycles = 0;
  bit     calm = 1'b0;
  int     rx_hold = 0;

  initial forever #10 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("** cubic_spline_evaluator: FAILED **");
      $finish;
    end
  end

  // receiver: random stalls, a counted hold-off when asked
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 18);
    end
  end

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) begin clip_seen = 1'b1; return 64'sd2147483647; end
    if (v < -64'sd2147483648) begin clip_seen = 1'b1; return -64'sd2147483648; end
    return v;
  endfunction

  function automatic longint floor_q(longint p);
    return p >>> FracW;
  endfunction

  // spline value or derivative at a point; updates the remembered interval
  function automatic spline_res_t evaluate(cse_pkg::func_e f, logic [31:0] pt);
    spline_res_t res;
    int cnt, i;
    longint v, x0, x1, y0, dy, dx, slope, r, t, outv;
    bit extra;
    cnt = (knot_cfg < 2) ? 2 : ((knot_cfg > KnotsMax) ? KnotsMax : int'(knot_cfg));
    i = (last_iv > cnt - 2) ? cnt - 2 : last_iv;
    clip_seen = 1'b0;
    extra = 1'b0;
    v = longint'($signed(pt));
    x0 = knot_tab[i];
    x1 = knot_tab[i+1];
    while (v < x0 && i > 0) begin
      i--;
      x0 = knot_tab[i];
      x1 = knot_tab[i+1];
    end
    if (v < x0) begin
      extra = 1'b1;
    end else begin
      while (v > x1 && i < cnt - 2) begin
        i++;
        x0 = knot_tab[i];
        x1 = knot_tab[i+1];
      end
      if (v > x1) extra = 1'b1;
    end
    if (extra) begin
      y0 = const_tab[i];
      dy = longint'(const_tab[i+1]) - y0;
      dx = x1 - x0;
      if (dx == 0) begin
        clip_seen = 1'b1;
        slope = (dy > 0) ? 64'sd2147483647 : ((dy < 0) ? -64'sd2147483648 : 0);
      end else begin
        slope = clip32((dy * (64'sd1 << FracW)) / dx);
      end
      outv = (f == cse_pkg::FUNC_DERIV) ? slope : clip32(y0 + floor_q(slope * (v - x0)));
    end else begin
      r = v - x0;
      if (f == cse_pkg::FUNC_VALUE) begin
        t = cub_tab[i];
        t = clip32(longint'(quad_tab[i]) + floor_q(t * r));
        t = clip32(longint'(lin_tab[i]) + floor_q(t * r));
        t = clip32(longint'(const_tab[i]) + floor_q(t * r));
      end else begin
        t = clip32(3 * longint'(cub_tab[i]));
        t = clip32(2 * longint'(quad_tab[i]) + floor_q(t * r));
        t = clip32(longint'(lin_tab[i]) + floor_q(t * r));
      end
      outv = t;
    end
    last_iv = i;
    res.value = outv[31:0];
    res.interval = i[5:0];
    res.extra = extra;
    res.clipped = clip_seen;
    return res;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        spline_res_t e;
        e = pending.pop_front();
        if (m_axis_tdata[31:0] !== e.value || m_axis_tdata[37:32] !== e.interval ||
            m_axis_tdata[38] !== e.extra || m_axis_tdata[39] !== e.clipped) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp val %h iv %0d ext %b sat %b, got val %h iv %0d ext %b sat %b",
                     e.value, e.interval, e.extra, e.clipped, m_axis_tdata[31:0],
                     m_axis_tdata[37:32], m_axis_tdata[38], m_axis_tdata[39]);
        end
      end
    end
  end

  // send one request and update the predictor when it is taken
  task automatic send_req(cse_pkg::func_e f, logic [31:0] pt, logic [5:0] idx = '0,
                          logic [31:0] kn = '0, logic [31:0] c0 = '0, logic [31:0] c1 = '0,
                          logic [31:0] c2 = '0, logic [31:0] c3 = '0);
    if (!calm) begin
      while ($urandom_range(99) < 18) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= f;
    s_axis_tdata <= {2'b00, c3, c2, c1, c0, kn, idx, pt};
    do @(posedge clk_i); while (!s_axis_tready);
    case (f)
      cse_pkg::FUNC_WRITE: begin
        knot_tab[idx] = kn; const_tab[idx] = c0; lin_tab[idx] = c1;
        quad_tab[idx] = c2; cub_tab[idx] = c3;
      end
      cse_pkg::FUNC_VALUE, cse_pkg::FUNC_DERIV: pending.push_back(evaluate(f, pt));
      default: ;
    endcase
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  // register write only once the block is quiet
  task automatic set_knot_count(logic [6:0] n);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 2'(cse_pkg::REG_KNOT_COUNT * 4); pwdata <= {25'd0, n};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    knot_cfg = n;
    @(posedge clk_i);
  endtask

  // coefficient with random magnitude
  function automatic logic [31:0] rand_q();
    logic [31:0] w;
    w = $urandom;
    return $signed(w) >>> $urandom_range(31);
  endfunction

  // rewrite entries 0..n-1 with increasing knots
  task automatic load_table(int n, int max_gap);
    logic signed [31:0] k;
    k = -$signed(32'($urandom_range(1 << 28)));
    for (int e = 0; e < n; e++) begin
      send_req(cse_pkg::FUNC_WRITE, $urandom, 6'(e), k, rand_q(), rand_q(), rand_q(),
               rand_q());
      k = k + 32'($urandom_range(max_gap, 1));
    end
  endtask

  // query point: mostly inside a random interval of the table in use
  function automatic logic [31:0] pick_point();
    int cnt, j, sel;
    longint a, b;
    cnt = (knot_cfg < 2) ? 2 : ((knot_cfg > KnotsMax) ? KnotsMax : int'(knot_cfg));
    sel = $urandom_range(99);
    if (sel < 8) return $urandom;
    if (sel < 18) begin
      a = (sel < 13) ? longint'(knot_tab[0]) - $urandom_range(1 << 20)
                     : longint'(knot_tab[cnt-1]) + $urandom_range(1 << 20);
      return a[31:0];
    end
    j = $urandom_range(cnt - 2);
    a = knot_tab[j];
    b = knot_tab[j+1];
    if (b <= a) return a[31:0];
    a = a + (longint'($urandom) % (b - a + 1));
    return a[31:0];
  endfunction

  task automatic test_table_load();
    // every entry written once, knots evenly spaced, other fields full-range
    for (int e = 0; e < KnotsMax; e++)
      send_req(cse_pkg::FUNC_WRITE, $urandom, 6'(e), 32'(e * 32'h0001_0000 - 32'h0020_0000),
               $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic test_extremes();
    set_knot_count(7'd2);
    send_req(cse_pkg::FUNC_VALUE, 32'h8000_0000);
    send_req(cse_pkg::FUNC_DERIV, 32'h7fff_ffff);
    send_req(cse_pkg::FUNC_VALUE, knot_tab[0]);
    send_req(cse_pkg::FUNC_DERIV, knot_tab[1]);
    send_req(cse_pkg::FUNC_NONE, $urandom);
    send_req(cse_pkg::FUNC_VALUE, knot_tab[0] + 32'h100);
    drain();
    // large tables: far walks both ways
    set_knot_count(7'd64);
    send_req(cse_pkg::FUNC_VALUE, knot_tab[63]);
    send_req(cse_pkg::FUNC_DERIV, knot_tab[0] + 1);
    send_req(cse_pkg::FUNC_VALUE, 32'h7fff_ffff);
    send_req(cse_pkg::FUNC_VALUE, 32'h8000_0000);
    drain();
  endtask

  task automatic test_zero_spacing();
    set_knot_count(7'd3);
    send_req(cse_pkg::FUNC_WRITE, 0, 6'd0, 32'h0001_0000, 32'h0000_5000, 0, 0, 0);
    send_req(cse_pkg::FUNC_WRITE, 0, 6'd1, 32'h0001_0000, 32'hffff_0000, 0, 0, 0);
    send_req(cse_pkg::FUNC_WRITE, 0, 6'd2, 32'h0001_0000, 32'hffff_0000, 0, 0, 0);
    send_req(cse_pkg::FUNC_VALUE, 32'h0000_0100);
    send_req(cse_pkg::FUNC_DERIV, 32'h0000_0100);
    send_req(cse_pkg::FUNC_VALUE, 32'h0002_0000);
    send_req(cse_pkg::FUNC_DERIV, 32'h0002_0000);
    send_req(cse_pkg::FUNC_WRITE, 0, 6'd0, 32'h0001_0000, 32'h8000_0000, 0, 0, 0);
    send_req(cse_pkg::FUNC_VALUE, 32'h0000_0100);
    drain();
  endtask

  task automatic test_count_clipping();
    logic [6:0] odd_counts[4] = '{7'd0, 7'd1, 7'd127, 7'd65};
    foreach (odd_counts[n]) begin
      set_knot_count(odd_counts[n]);
      send_req(cse_pkg::func_e'($urandom_range(0, 0)), pick_point());
      send_req(cse_pkg::FUNC_DERIV, pick_point());
      drain();
    end
  endtask

  task automatic test_backpressure();
    set_knot_count(7'd16);
    rx_hold = 600;
    for (int n = 0; n < 12; n++) send_req(cse_pkg::func_e'($urandom_range(1)), pick_point());
    drain();
  endtask

  task automatic test_random(int queries);
    int done, gap;
    done = 0;
    while (done < queries) begin
      set_knot_count((done % 5 == 0) ? 7'd64 : 7'($urandom_range(24, 2)));
      gap = 1 << $urandom_range(22, 4);
      load_table((knot_cfg > KnotsMax) ? KnotsMax : int'(knot_cfg), gap);
      calm = ($urandom_range(3) == 0);
      for (int n = 0; n < 60 && done < queries; n++) begin
        case ($urandom_range(19))
          0: send_req(cse_pkg::FUNC_NONE, $urandom);
          1: begin
            logic [5:0] e;
            e = 6'($urandom_range(int'(knot_cfg) - 1));
            send_req(cse_pkg::FUNC_WRITE, $urandom, e, knot_tab[e], rand_q(), rand_q(),
                     rand_q(), rand_q());
          end
          default: begin
            send_req(cse_pkg::func_e'($urandom_range(1)), pick_point());
            done++;
          end
        endcase
      end
      calm = 1'b0;
      drain();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_load();
    test_extremes();
    test_zero_spacing();
    test_table_load();
    test_count_clipping();
    test_backpressure();
    test_random(400);
    drain();
    if (errors == 0) begin
      $display("** cubic_spline_evaluator: PASSED **");
    end else begin
      $display("** cubic_spline_evaluator: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
+incdir+design
design/cse_pkg.sv
design/cse_ram.sv
design/cse_div.sv
design/cubic_spline_evaluator.sv
test/tb.sv
